@@ rtl/tcbc_pkg.sv @@
// Shared types and constants for the thermal class blink controller.
// Used by tcbc_temp_pipe and thermal_class_blink_controller; depends on nothing.
package tcbc_pkg;

    localparam int OP_W     = 2;
    localparam int CLASS_W  = 2;
    localparam int CNT_W    = 9;
    localparam int WHOLE_W  = 10;
    localparam int HUND_W   = 8;
    localparam int HZ_W     = 5;
    localparam int M_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_LOWER  = 2'd2,
        OP_HIGHER = 2'd3
    } op_t;

    // Sensor conversion: milli = trunc(-RAW_GAIN * raw / 10) + OFFSET_MILLI.
    localparam int RAW_GAIN     = 1191;
    localparam int RAW_GAIN_W   = 11;
    localparam int OFFSET_MILLI = 223000;

    // Saturation limits of the whole-degree value.
    localparam int WHOLE_POS_MAX = 511;
    localparam int WHOLE_NEG_MAX = 512;

    // Heat class = trunc((whole - CLASS_BASE) / CLASS_STEP), clamped to 0..3.
    localparam int CLASS_BASE = 35;
    localparam int CLASS_STEP = 5;
    localparam logic [CLASS_W-1:0] CLASS_MIN = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MAX = 2'd3;

    localparam logic signed [WHOLE_W-1:0] WHOLE_RESET = -10'sd50;

    localparam logic [CNT_W-1:0] BLINK_PERIOD_MS [4] = '{9'd500, 9'd200, 9'd100, 9'd50};
    localparam logic [HZ_W-1:0]  BLINK_LABEL_HZ  [4] = '{5'd2, 5'd5, 5'd10, 5'd20};

    // Control that travels alongside each request through the pipeline.
    typedef struct packed {
        logic valid;
        op_t  op;
    } tcbc_ctl_t;

    // Converted temperature and the class it implies in automatic mode.
    typedef struct packed {
        logic signed [WHOLE_W-1:0] whole;
        logic signed [HUND_W-1:0]  hund;
        logic [CLASS_W-1:0]        auto_class;
    } tcbc_temp_t;

endpackage

@@ rtl/tcbc_temp_pipe.sv @@
// Five-stage pipeline that turns a raw sensor reading into degrees, hundredths
// and an automatic heat class. Depends on tcbc_pkg.
module tcbc_temp_pipe #(
    parameter int RAW_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  tcbc_pkg::tcbc_ctl_t     ctl_in,
    input  logic [RAW_BITS-1:0]     raw_in,
    output tcbc_pkg::tcbc_ctl_t     ctl_out,
    output tcbc_pkg::tcbc_temp_t    res_out
);
    import tcbc_pkg::*;

    localparam int STAGES = 5;
    // RAW_GAIN fits in RAW_GAIN_W bits, so the product fits in P_W bits.
    localparam int P_W    = RAW_BITS + RAW_GAIN_W;
    localparam int K10    = P_W + 4;
    localparam int K1000  = P_W + 10;
    localparam longint unsigned RCP10   = ((64'd1 << K10) + 64'd9) / 64'd10;
    localparam longint unsigned RCP1000 = ((64'd1 << K1000) + 64'd999) / 64'd1000;
    localparam int D1000_W = P_W - 9;
    localparam int D10_W   = P_W - 3;

    tcbc_ctl_t ctl_reg [STAGES];

    logic [P_W-1:0]     prod_reg;
    logic [P_W-1:0]     quot_reg;
    logic               neg_reg;
    logic [P_W-1:0]     mag_reg;
    logic               neg2_reg;
    logic [D1000_W-1:0] d1000_reg;
    logic [D10_W-1:0]   d10_reg;
    tcbc_temp_t         res_reg;

    logic [2*P_W:0]       quot_prod;
    logic [P_W-1:0]       quot_next;
    logic [P_W-1:0]       offset;
    logic [2*P_W:0]       d1000_prod;
    logic [2*P_W:0]       d10_prod;
    logic [D10_W-1:0]     hund_wide;
    logic [HUND_W-2:0]    hund_mag;
    logic [WHOLE_W:0]     whole_mag;
    logic [WHOLE_W:0]     whole_limit;
    logic signed [WHOLE_W:0] whole_wide;
    tcbc_temp_t           res_next;

    assign offset     = P_W'(OFFSET_MILLI);
    assign quot_prod  = (2*P_W+1)'(prod_reg) * (2*P_W+1)'(RCP10[P_W:0]);
    assign quot_next  = quot_prod[K10 +: P_W];
    assign d1000_prod = (2*P_W+1)'(mag_reg) * (2*P_W+1)'(RCP1000[P_W:0]);
    assign d10_prod   = (2*P_W+1)'(mag_reg) * (2*P_W+1)'(RCP10[P_W:0]);

    always_comb begin
        // Remainder of the tens by one hundred, from the two quotients.
        hund_wide   = d10_reg - D10_W'(d1000_reg) * D10_W'(100);
        hund_mag    = hund_wide[HUND_W-2:0];
        whole_limit = neg2_reg ? (WHOLE_W+1)'(WHOLE_NEG_MAX) : (WHOLE_W+1)'(WHOLE_POS_MAX);
        if (D1000_W'(whole_limit) < d1000_reg || D1000_W < WHOLE_W + 1 &&
            (WHOLE_W+1)'(d1000_reg) > whole_limit) begin
            whole_mag = whole_limit;
        end else begin
            whole_mag = (WHOLE_W+1)'(d1000_reg);
        end
        whole_wide        = neg2_reg ? -$signed(whole_mag) : $signed(whole_mag);
        res_next.whole    = whole_wide[WHOLE_W-1:0];
        res_next.hund     = neg2_reg ? -$signed({1'b0, hund_mag}) : $signed({1'b0, hund_mag});
        if (res_next.whole >= WHOLE_W'(CLASS_BASE + 3*CLASS_STEP)) begin
            res_next.auto_class = CLASS_MAX;
        end else if (res_next.whole >= WHOLE_W'(CLASS_BASE + 2*CLASS_STEP)) begin
            res_next.auto_class = 2'd2;
        end else if (res_next.whole >= WHOLE_W'(CLASS_BASE + CLASS_STEP)) begin
            res_next.auto_class = 2'd1;
        end else begin
            res_next.auto_class = CLASS_MIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                ctl_reg[i] <= '0;
            end
        end else if (en) begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < STAGES; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= P_W'(raw_in) * P_W'(RAW_GAIN);
            quot_reg  <= quot_next;
            neg_reg   <= quot_reg > offset;
            mag_reg   <= (quot_reg > offset) ? quot_reg - offset : offset - quot_reg;
            neg2_reg  <= neg_reg;
            d1000_reg <= d1000_prod[K1000 +: D1000_W];
            d10_reg   <= d10_prod[K10 +: D10_W];
            res_reg   <= res_next;
        end
    end

    assign ctl_out = ctl_reg[STAGES-1];
    assign res_out = res_reg;

endmodule

@@ rtl/thermal_class_blink_controller.sv @@
// Top level of the thermal class blink controller: input register, conversion
// pipeline, blink state and output register. Depends on tcbc_pkg and tcbc_temp_pipe.
//
// Usage. Each request on the s_ channel is a millisecond tick, a raw sensor
// sample, or a manual lower or higher command, selected by s_tuser. Every
// request yields exactly one result on the m_ channel with the LED level, the
// last measured temperature in whole degrees and hundredths, the heat class
// and its blink frequency label. The manual_mode register must be written
// through cfg_we and cfg_wdata by the user only while no request is in
// flight; the block itself does not enforce this. One request is accepted
// every cycle while the receiver does not stall; the rate is set by the
// pipeline that converts samples, and every request passes through it so
// that results leave in order. State is only updated in the last stage, so
// consecutive requests see each other's effects. Reset clears the pipeline,
// the LED, the tick count and the class, sets the temperature to minus fifty
// degrees and selects automatic mode. When the receiver stalls, the whole
// pipeline holds and s_tready drops, so nothing is lost or repeated; the
// output register keeps its result stable.
module thermal_class_blink_controller #(
    parameter int RAW_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,    // manual_mode
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((RAW_BITS+7)/8)*8-1:0]    s_tdata,      // raw_sample
    input  logic [tcbc_pkg::OP_W-1:0]        s_tuser,      // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // led_on, temp_whole, temp_hundredths, class_out, blink_hz, zero padding
    output logic [tcbc_pkg::M_DATA_W-1:0]    m_tdata
);
    import tcbc_pkg::*;

    localparam int FIELDS_W = 1 + WHOLE_W + HUND_W + CLASS_W + HZ_W;

    logic                       en;
    tcbc_ctl_t                  in_ctl_reg;
    logic [RAW_BITS-1:0]        raw_reg;
    tcbc_ctl_t                  pipe_ctl;
    tcbc_temp_t                 pipe_res;

    logic                       manual_reg;
    logic                       led_reg, led_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next, cnt_inc;
    logic [CLASS_W-1:0]         class_reg, class_next;
    logic signed [WHOLE_W-1:0]  whole_reg, whole_next;
    logic signed [HUND_W-1:0]   hund_reg, hund_next;
    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg, m_tdata_next;

    // The pipeline advances whenever the output register is empty or being read.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_reg <= 1'b0;
        end else if (cfg_we) begin
            manual_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctl_reg <= '0;
        end else if (en) begin
            in_ctl_reg.valid <= s_tvalid;
            in_ctl_reg.op    <= op_t'(s_tuser);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_reg <= s_tdata[RAW_BITS-1:0];
        end
    end

    tcbc_temp_pipe #(
        .RAW_BITS (RAW_BITS)
    ) u_temp_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (in_ctl_reg),
        .raw_in  (raw_reg),
        .ctl_out (pipe_ctl),
        .res_out (pipe_res)
    );

    // Final stage: apply the request to the blink state and form the result.
    always_comb begin
        led_next   = led_reg;
        cnt_next   = cnt_reg;
        class_next = class_reg;
        whole_next = whole_reg;
        hund_next  = hund_reg;
        cnt_inc    = cnt_reg + 1'b1;
        if (pipe_ctl.valid) begin
            unique case (pipe_ctl.op)
                OP_TICK: begin
                    // Toggle on the tick that reaches the period of the current class.
                    if (cnt_inc >= BLINK_PERIOD_MS[class_reg]) begin
                        led_next = ~led_reg;
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                OP_SAMPLE: begin
                    whole_next = pipe_res.whole;
                    hund_next  = pipe_res.hund;
                    if (!manual_reg) begin
                        class_next = pipe_res.auto_class;
                    end
                end
                OP_LOWER: begin
                    if (manual_reg && class_reg != CLASS_MIN) begin
                        class_next = class_reg - 1'b1;
                    end
                end
                OP_HIGHER: begin
                    if (manual_reg && class_reg != CLASS_MAX) begin
                        class_next = class_reg + 1'b1;
                    end
                end
            endcase
        end
        m_tdata_next = M_DATA_W'({BLINK_LABEL_HZ[class_next], class_next, hund_next,
                                  whole_next, led_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg      <= 1'b0;
            cnt_reg      <= '0;
            class_reg    <= CLASS_MIN;
            whole_reg    <= WHOLE_RESET;
            hund_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            led_reg      <= led_next;
            cnt_reg      <= cnt_next;
            class_reg    <= class_next;
            whole_reg    <= whole_next;
            hund_reg     <= hund_next;
            m_tvalid_reg <= pipe_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    if (FIELDS_W > M_DATA_W) begin : g_width_check
        $error("Result fields do not fit in m_tdata");
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for thermal_class_blink_controller.
// Drives ticks, sensor samples and class commands, predicts every result in
// the bench, and depends only on the RTL and tcbc_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcbc_pkg::*;

    localparam int S_DATA_W      = 16;
    localparam int RAW_W         = 12;
    localparam int CYCLE_LIMIT   = 400000;
    // Long enough for a request to pass through the whole block, with margin.
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;

    // Blink period in milliseconds and the frequency label, both by heat class.
    localparam int PERIOD_MS [4] = '{500, 200, 100, 50};
    localparam int LABEL_HZ  [4] = '{2, 5, 10, 20};

    // One request as the driver presents it.
    typedef struct {
        op_t                 op;
        logic [S_DATA_W-1:0] raw;
    } blink_req_t;

    // One result, split into its fields.
    typedef struct {
        logic                      led;
        logic signed [WHOLE_W-1:0] whole;
        logic signed [HUND_W-1:0]  hund;
        logic [CLASS_W-1:0]        cls;
        logic [HZ_W-1:0]           hz;
        logic [5:0]                pad;
    } blink_status_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Requests waiting to be sent, and results expected back, oldest first.
    blink_req_t    req_q[$];
    blink_status_t status_q[$];

    // Bench copy of the block's state and its mode register.
    bit                   mode_manual;
    logic                 led_level;
    logic [CNT_W-1:0]     ms_count;
    logic [CLASS_W-1:0]   heat_class;
    int                   last_whole;
    int                   last_hund;

    int  err_count;
    int  cycle_count;
    bit  req_taken;

    // Sender burst shaping and receiver stall pattern.
    int  burst_left;
    int  gap_left;
    int  ready_mode;
    int  ready_epoch;
    int  ready_run;
    bit  ready_hold;

    thermal_class_blink_controller #(
        .RAW_BITS (RAW_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one accepted request to the bench state and returns the result
    // that the block must produce for it.
    task automatic apply_request(input blink_req_t r, output blink_status_t s);
        int raw;
        int milli;
        int whole;
        int cls;
        begin
            case (r.op)
                OP_TICK: begin
                    // The count is nine bits wide and wraps, as in the block.
                    ms_count = ms_count + 1'b1;
                    if (ms_count >= PERIOD_MS[heat_class]) begin
                        led_level = ~led_level;
                        ms_count  = '0;
                    end
                end
                OP_SAMPLE: begin
                    // Only the low RAW_W bits of the sample count. Signed
                    // division truncates toward zero, just like the conversion.
                    raw   = int'(r.raw[RAW_W-1:0]);
                    milli = (-RAW_GAIN * raw) / 10 + 223000;
                    whole = milli / 1000;
                    if (whole > 511) whole = 511;
                    if (whole < -512) whole = -512;
                    last_whole = whole;
                    last_hund  = (milli / 10) % 100;
                    if (!mode_manual) begin
                        cls = (whole - 35) / 5;
                        if (cls < 0) cls = 0;
                        if (cls > 3) cls = 3;
                        heat_class = cls[CLASS_W-1:0];
                    end
                end
                OP_LOWER: begin
                    if (mode_manual && heat_class != CLASS_MIN) heat_class = heat_class - 1'b1;
                end
                default: begin
                    if (mode_manual && heat_class != CLASS_MAX) heat_class = heat_class + 1'b1;
                end
            endcase
            s.led   = led_level;
            s.whole = last_whole[WHOLE_W-1:0];
            s.hund  = last_hund[HUND_W-1:0];
            s.cls   = heat_class;
            s.hz    = HZ_W'(LABEL_HZ[heat_class]);
            s.pad   = '0;
        end
    endtask

    // Sender. A request that is up stays up until it is taken; between bursts
    // of random length the sender idles for a random number of cycles, and
    // often for none at all, so long back-to-back stretches occur too.
    always @(negedge aclk) begin
        if (s_tvalid && !req_taken) begin
            // Hold the current request.
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= req_q[0].raw;
            s_tuser  <= req_q[0].op;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver. Every so often it picks a new behavior: always ready, ready
    // at random three times in four, or alternating runs of ready and stall.
    always @(negedge aclk) begin
        if (ready_epoch == 0) begin
            ready_mode  = $urandom_range(0, 2);
            ready_epoch = $urandom_range(50, 300);
        end else begin
            ready_epoch--;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (ready_run == 0) begin
                    ready_hold = !ready_hold;
                    ready_run  = ready_hold ? $urandom_range(1, 12) : $urandom_range(1, 8);
                end else begin
                    ready_run--;
                end
                m_tready <= ready_hold;
            end
        endcase
    end

    // Input side: every accepted request is predicted at once. The state only
    // changes in acceptance order, so that is also the order of the results.
    always @(posedge aclk) begin
        blink_status_t s;
        req_taken = aresetn && s_tvalid && s_tready;
        if (req_taken) begin
            apply_request(req_q[0], s);
            req_q.pop_front();
            status_q.push_back(s);
        end
    end

    // Output side: each accepted result is compared with the oldest expected one.
    always @(posedge aclk) begin
        blink_status_t got;
        blink_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.led   = m_tdata[0];
            got.whole = m_tdata[10:1];
            got.hund  = m_tdata[18:11];
            got.cls   = m_tdata[20:19];
            got.hz    = m_tdata[25:21];
            got.pad   = m_tdata[31:26];
            if (status_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result: led=%0d whole=%0d hund=%0d class=%0d hz=%0d",
                             got.led, got.whole, got.hund, got.cls, got.hz);
            end else begin
                want = status_q.pop_front();
                if (got.led !== want.led || got.whole !== want.whole ||
                    got.hund !== want.hund || got.cls !== want.cls ||
                    got.hz !== want.hz || got.pad !== want.pad) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display({"mismatch: expected led=%0d whole=%0d hund=%0d class=%0d",
                                  " hz=%0d pad=%0d, got led=%0d whole=%0d hund=%0d class=%0d",
                                  " hz=%0d pad=%0d"},
                                 want.led, want.whole, want.hund, want.cls, want.hz, want.pad,
                                 got.led, got.whole, got.hund, got.cls, got.hz, got.pad);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_request(input op_t op, input logic [S_DATA_W-1:0] raw);
        blink_req_t r;
        begin
            r.op  = op;
            r.raw = raw;
            req_q.push_back(r);
        end
    endtask

    // Blocks until every queued request has been sent and answered.
    task automatic wait_idle();
        while (req_q.size() != 0 || status_q.size() != 0) @(posedge aclk);
    endtask

    // The mode register is only written with nothing in flight; the short
    // pause lets the pipeline empty completely before the write.
    task automatic write_mode(input bit value);
        begin
            wait_idle();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            @(negedge aclk);
            cfg_we      <= 1'b1;
            cfg_wdata   <= value;
            mode_manual  = value;
            @(negedge aclk);
            cfg_we      <= 1'b0;
        end
    endtask

    // Sample values cluster around the class boundaries (35 to 50 degrees
    // lies near raw 1450..1580), with full-range values and both extremes
    // mixed in. Now and then the bits above the sensor width are set as well,
    // which the block must ignore.
    function automatic logic [S_DATA_W-1:0] pick_raw();
        logic [S_DATA_W-1:0] v;
        begin
            case ($urandom_range(0, 3))
                0, 1: v = S_DATA_W'($urandom_range(1400, 1650));
                2:    v = S_DATA_W'($urandom_range(0, 4095));
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = '0;
                        1: v = 16'd4095;
                        2: v = S_DATA_W'($urandom_range(0, 60));
                        default: v = S_DATA_W'($urandom_range(4030, 4095));
                    endcase
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                v[S_DATA_W-1:RAW_W] = (S_DATA_W-RAW_W)'($urandom_range(1, 15));
            return v;
        end
    endfunction

    // Fills one random phase. Ticks dominate so that the LED really blinks;
    // class commands are common in manual mode, where they take effect, and
    // rare in automatic mode, where they are ignored and so are not counted.
    task automatic queue_random(input int n);
        int   done;
        int   pick;
        op_t  op;
        begin
            done = 0;
            while (done < n) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) op = OP_TICK;
                else if (pick < 78) op = OP_SAMPLE;
                else if (mode_manual || pick >= 95) op = (pick % 2 == 0) ? OP_LOWER : OP_HIGHER;
                else op = OP_TICK;
                queue_request(op, (op == OP_SAMPLE) ? pick_raw() : 16'($urandom));
                if (op == OP_TICK || op == OP_SAMPLE || mode_manual) done++;
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        m_tready    = 1'b0;
        req_taken   = 1'b0;
        burst_left  = 0;
        gap_left    = 0;
        ready_mode  = 0;
        ready_epoch = 0;
        ready_run   = 0;
        ready_hold  = 1'b0;
        err_count   = 0;
        cycle_count = 0;

        // State right after reset: automatic mode, class 0, minus fifty degrees.
        mode_manual = 1'b0;
        led_level   = 1'b0;
        ms_count    = '0;
        heat_class  = CLASS_MIN;
        last_whole  = -50;
        last_hund   = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed, automatic mode: the reset state, the hottest and coldest
        // samples, samples at the class boundaries, a sample whose unused
        // upper bits are set, and class commands that must be ignored.
        queue_request(OP_TICK,   16'd0);
        queue_request(OP_SAMPLE, 16'd0);
        queue_request(OP_SAMPLE, 16'd4095);
        queue_request(OP_SAMPLE, 16'd1578);
        queue_request(OP_SAMPLE, 16'd1536);
        queue_request(OP_SAMPLE, 16'd1494);
        queue_request(OP_SAMPLE, 16'hF000 | 16'd1452);
        queue_request(OP_LOWER,  16'hFFFF);
        queue_request(OP_HIGHER, 16'h0000);
        queue_request(OP_TICK,   16'd0);

        // Directed, manual mode: raise at the top class, step down to the
        // bottom and past it, then samples that must leave the class alone.
        write_mode(1'b1);
        queue_request(OP_HIGHER, 16'd0);
        queue_request(OP_HIGHER, 16'd0);
        queue_request(OP_LOWER,  16'd0);
        queue_request(OP_LOWER,  16'd0);
        queue_request(OP_LOWER,  16'd0);
        queue_request(OP_LOWER,  16'd0);
        queue_request(OP_SAMPLE, 16'd0);
        queue_request(OP_HIGHER, 16'd0);
        queue_request(OP_TICK,   16'd0);
        queue_request(OP_SAMPLE, 16'd4095);

        // Random phases that switch between the two modes.
        write_mode(1'b0);
        queue_random(140);
        write_mode(1'b1);
        queue_random(140);
        write_mode(1'b0);
        queue_random(140);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && status_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
